@@ design/htb_pkg.sv @@
// Shared types and constants of the height weighted texel blend.
package htb_pkg;

  localparam int HEIGHT_W  = 16;
  localparam int TEXEL_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int WEIGHT_W  = 17;
  localparam int TOTAL_W   = 19;
  localparam int NUM_TEX   = 4;
  localparam int IDX_W     = 2;
  localparam int DROP_W    = 21;
  localparam int ACC_W     = 26;
  localparam int QBITS     = 17;
  localparam int BIT_W     = 5;

  // Q1.16 one and quarter
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_QUARTER = 17'd16384;

  // Tent centers in Q2.14: 0.0, 0.3, 0.6, 0.9
  localparam logic signed [HEIGHT_W:0] TENT_CENTER [NUM_TEX] =
    '{17'sd0, 17'sd4915, 17'sd9830, 17'sd14746};

  // The lowland tent is the narrow one (slope 20 instead of 16)
  localparam logic [IDX_W-1:0] IDX_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] IDX_LAST = 2'd3;

  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

@@ design/htb_if.sv @@
// Valid/ready channel interfaces for the input items and the blend results.
interface htb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [htb_pkg::HEIGHT_W-1:0] height;
  htb_pkg::texel_t                    texel_low;
  htb_pkg::texel_t                    texel_medium;
  htb_pkg::texel_t                    texel_high;
  htb_pkg::texel_t                    texel_very_high;

  modport source (
    output valid, action, height, texel_low, texel_medium, texel_high, texel_very_high,
    input  ready
  );
  modport sink (
    input  valid, action, height, texel_low, texel_medium, texel_high, texel_very_high,
    output ready
  );
endinterface

interface htb_out_if;
  logic           valid;
  logic           ready;
  htb_pkg::chan_t red;
  htb_pkg::chan_t green;
  htb_pkg::chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ design/height_weighted_texel_blend_top.sv @@
// Top level of the height weighted texel blend: sequencer, divider and blend MAC.
//
//   channel   dir  payload                                        transfer when
//   in_chan   in   action, height, texel_low/medium/high/very_high valid && ready
//   out_chan  out  red, green, blue                               valid && ready
//
// A blend item runs 4 multiply-accumulate steps, one per texel, through the shared
// 3-channel MAC, then a finish step loads the output register once it is free.
// A height item computes the 4 tents, then runs the shared compare-subtract divider
// once per weight (not at all when every tent is zero).
// in_chan.ready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next transfer. Reset sets all weights to one quarter.
module height_weighted_texel_blend_top (
  input  logic       clk,
  input  logic       rst_n,
  htb_in_if.sink     in_chan,
  htb_out_if.source  out_chan
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TENT  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_BLEND = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                          state_r;
  logic [htb_pkg::IDX_W-1:0]           idx_r;
  logic [htb_pkg::BIT_W-1:0]           bit_r;
  logic signed [htb_pkg::HEIGHT_W-1:0] height_r;
  htb_pkg::texel_t                     texel_r  [htb_pkg::NUM_TEX];
  htb_pkg::weight_t                    tent_r   [htb_pkg::NUM_TEX];
  htb_pkg::weight_t                    weight_r [htb_pkg::NUM_TEX];
  logic [htb_pkg::TOTAL_W-1:0]         total_r;
  logic [htb_pkg::TOTAL_W-1:0]         rem_r;
  logic [htb_pkg::QBITS-2:0]           quo_r;
  logic [htb_pkg::ACC_W-1:0]           acc_r [3];
  logic                                out_valid_r;
  htb_pkg::chan_t                      red_r, green_r, blue_r;

  logic                                in_xfer;
  logic                                out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Tent of the current texel: 1 - slope * |h - center|, clamped at zero
  logic signed [htb_pkg::HEIGHT_W:0] diff;
  logic [htb_pkg::HEIGHT_W:0]        dist_abs;
  logic [htb_pkg::DROP_W-1:0]        drop;
  htb_pkg::weight_t                  tent;
  logic [htb_pkg::TOTAL_W-1:0]       total_sum;

  always_comb begin
    diff = {height_r[htb_pkg::HEIGHT_W-1], height_r} - htb_pkg::TENT_CENTER[idx_r];
    dist_abs = diff[htb_pkg::HEIGHT_W] ? 17'(-diff) : 17'(diff);
    drop = {dist_abs, 4'b0000} +
           ((idx_r == htb_pkg::IDX_LOW) ? {2'b00, dist_abs, 2'b00} : '0);
    if (drop >= htb_pkg::DROP_W'(htb_pkg::WEIGHT_ONE)) begin
      tent = '0;
    end else begin
      tent = htb_pkg::WEIGHT_W'(htb_pkg::DROP_W'(htb_pkg::WEIGHT_ONE) - drop);
    end
    total_sum = total_r + htb_pkg::TOTAL_W'(tent);
  end

  // Shared restoring divider step: tent * 2^16 / total, one quotient bit a cycle
  logic [htb_pkg::TOTAL_W:0]   trial;
  logic                        qbit;
  logic [htb_pkg::TOTAL_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, (bit_r == htb_pkg::BIT_W'(htb_pkg::QBITS - 1)) ? tent_r[idx_r][0]
                                                                     : 1'b0};
    qbit     = (trial >= {1'b0, total_r});
    rem_step = qbit ? htb_pkg::TOTAL_W'(trial - {1'b0, total_r})
                    : htb_pkg::TOTAL_W'(trial);
  end

  // Shared blend MAC: one texel's three channels per cycle
  htb_pkg::texel_t             cur_texel;
  logic [htb_pkg::ACC_W-1:0]   prod [3];

  always_comb begin
    cur_texel = texel_r[idx_r];
    for (int c = 0; c < 3; c++) begin
      prod[c] = htb_pkg::ACC_W'(weight_r[idx_r]) *
                htb_pkg::ACC_W'(cur_texel[htb_pkg::CHAN_W*(2-c) +: htb_pkg::CHAN_W]);
    end
  end

  // Saturate a channel sum after dropping the 16 fraction bits
  function automatic htb_pkg::chan_t sat_chan(input logic [htb_pkg::ACC_W-1:0] acc);
    logic [htb_pkg::ACC_W-17:0] whole;
    whole = acc[htb_pkg::ACC_W-1:16];
    sat_chan = (whole > 10'd255) ? 8'hFF : whole[7:0];
  endfunction

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < htb_pkg::NUM_TEX; k++) begin
        weight_r[k] <= htb_pkg::WEIGHT_QUARTER;
      end
    end else begin
      // result drains; the finish step reloads the register in that same cycle
      if (out_valid_r && out_chan.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_r    <= '0;
            height_r <= in_chan.height;
            total_r  <= '0;
            texel_r[0] <= in_chan.texel_low;
            texel_r[1] <= in_chan.texel_medium;
            texel_r[2] <= in_chan.texel_high;
            texel_r[3] <= in_chan.texel_very_high;
            for (int c = 0; c < 3; c++) begin
              acc_r[c] <= '0;
            end
            state_r <= in_chan.action ? ST_BLEND : ST_TENT;
          end
        end
        ST_TENT: begin
          tent_r[idx_r] <= tent;
          total_r       <= total_sum;
          if (idx_r == htb_pkg::IDX_LAST) begin
            idx_r <= '0;
            if (total_sum == '0) begin
              // height outside every tent: even quarter each
              for (int k = 0; k < htb_pkg::NUM_TEX; k++) begin
                weight_r[k] <= htb_pkg::WEIGHT_QUARTER;
              end
              state_r <= ST_IDLE;
            end else begin
              rem_r   <= htb_pkg::TOTAL_W'(tent_r[0] >> 1);
              quo_r   <= '0;
              bit_r   <= htb_pkg::BIT_W'(htb_pkg::QBITS - 1);
              state_r <= ST_DIV;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (bit_r == '0) begin
            weight_r[idx_r] <= {quo_r, qbit};
            if (idx_r == htb_pkg::IDX_LAST) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
              rem_r <= htb_pkg::TOTAL_W'(tent_r[idx_r + 1'b1] >> 1);
              quo_r <= '0;
              bit_r <= htb_pkg::BIT_W'(htb_pkg::QBITS - 1);
            end
          end else begin
            rem_r <= rem_step;
            quo_r <= {quo_r[htb_pkg::QBITS-3:0], qbit};
            bit_r <= bit_r - 1'b1;
          end
        end
        ST_BLEND: begin
          for (int c = 0; c < 3; c++) begin
            acc_r[c] <= acc_r[c] + prod[c];
          end
          if (idx_r == htb_pkg::IDX_LAST) begin
            state_r <= ST_FIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            red_r       <= sat_chan(acc_r[0]);
            green_r     <= sat_chan(acc_r[1]);
            blue_r      <= sat_chan(acc_r[2]);
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;

  // Checks
  logic [htb_pkg::TOTAL_W-1:0] weight_sum;
  assign weight_sum = htb_pkg::TOTAL_W'(weight_r[0]) + htb_pkg::TOTAL_W'(weight_r[1]) +
                      htb_pkg::TOTAL_W'(weight_r[2]) + htb_pkg::TOTAL_W'(weight_r[3]);

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish step");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < total_r))
    else $error("divider remainder not below the tent total");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (weight_sum <= htb_pkg::TOTAL_W'(htb_pkg::WEIGHT_ONE)))
    else $error("blend weights sum above one");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_free) |=> (state_r == ST_FIN))
    else $error("finish step left while the output register is full");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the height weighted texel blend with its own weight predictor.
module tb_top;

  // Item codes
  localparam logic ACT_HEIGHT = 1'b0;
  localparam logic ACT_BLEND  = 1'b1;

  localparam int unsigned Q16_ONE     = 65536;
  localparam int unsigned Q16_QUARTER = 16384;
  localparam int unsigned CHAN_MAX    = 255;

  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASE1_AT    = 620;
  localparam int PHASE2_AT    = 1240;
  localparam int HOLD_AT      = 1300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic               action;
    logic signed [15:0] height;
    htb_pkg::texel_t    tex_low;
    htb_pkg::texel_t    tex_med;
    htb_pkg::texel_t    tex_high;
    htb_pkg::texel_t    tex_vhigh;
  } blend_item_t;

  typedef struct packed {
    htb_pkg::chan_t red;
    htb_pkg::chan_t green;
    htb_pkg::chan_t blue;
  } rgb_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  htb_in_if  in_chan ();
  htb_out_if out_chan ();

  height_weighted_texel_blend_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Stimulus side registers, known from time zero
  logic        drv_valid  = 1'b0;
  blend_item_t drv_item   = '0;
  logic        sink_ready = 1'b0;

  assign in_chan.valid           = drv_valid;
  assign in_chan.action          = drv_item.action;
  assign in_chan.height          = drv_item.height;
  assign in_chan.texel_low       = drv_item.tex_low;
  assign in_chan.texel_medium    = drv_item.tex_med;
  assign in_chan.texel_high      = drv_item.tex_high;
  assign in_chan.texel_very_high = drv_item.tex_vhigh;
  assign out_chan.ready          = sink_ready;

  blend_item_t      stim_items [$];
  rgb_t             expect_rgb [$];
  htb_pkg::weight_t weight_q16 [4];

  logic in_taken     = 1'b0;
  int   accepted_cnt = 0;
  int   height_cnt   = 0;
  int   blend_cnt    = 0;
  int   checked_cnt  = 0;
  int   fail_cnt     = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  int   cycle_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tent weights of a height, clamped and normalized to a Q1.16 sum of one
  function automatic void set_height_weights(input logic signed [15:0] h);
    int unsigned tent [4];
    longint unsigned total;
    int mid;
    int slope;
    int diff;
    int unsigned drop;
    int k;
    total = 0;
    for (k = 0; k < 4; k++) begin
      case (k)
        0:       begin mid = 0;     slope = 20; end
        1:       begin mid = 4915;  slope = 16; end
        2:       begin mid = 9830;  slope = 16; end
        default: begin mid = 14746; slope = 16; end
      endcase
      diff = int'(h) - mid;
      if (diff < 0) diff = -diff;
      drop = int'(diff) * slope;
      tent[k] = (drop >= Q16_ONE) ? 0 : Q16_ONE - drop;
      total += tent[k];
    end
    for (k = 0; k < 4; k++) begin
      if (total == 0)
        weight_q16[k] = htb_pkg::weight_t'(Q16_QUARTER);
      else
        weight_q16[k] = htb_pkg::weight_t'((longint'(tent[k]) * Q16_ONE) / total);
    end
  endfunction

  // Weighted RGB sum of the four texels, truncated and saturated
  function automatic rgb_t blend_pixel(input blend_item_t it);
    htb_pkg::texel_t tx [4];
    longint unsigned acc [3];
    rgb_t res;
    int c;
    int k;
    tx[0] = it.tex_low;
    tx[1] = it.tex_med;
    tx[2] = it.tex_high;
    tx[3] = it.tex_vhigh;
    for (c = 0; c < 3; c++) begin
      acc[c] = 0;
      for (k = 0; k < 4; k++)
        acc[c] += longint'(weight_q16[k]) * longint'(tx[k][(2 - c) * 8 +: 8]);
      acc[c] = acc[c] >> 16;
      if (acc[c] > CHAN_MAX) acc[c] = CHAN_MAX;
    end
    res.red   = htb_pkg::chan_t'(acc[0]);
    res.green = htb_pkg::chan_t'(acc[1]);
    res.blue  = htb_pkg::chan_t'(acc[2]);
    return res;
  endfunction

  function automatic blend_item_t mk_item(input logic act, input int h,
                                          input htb_pkg::texel_t tl,
                                          input htb_pkg::texel_t tm,
                                          input htb_pkg::texel_t th,
                                          input htb_pkg::texel_t tv);
    blend_item_t it;
    it.action    = act;
    it.height    = h[15:0];
    it.tex_low   = tl;
    it.tex_med   = tm;
    it.tex_high  = th;
    it.tex_vhigh = tv;
    return it;
  endfunction

  function automatic htb_pkg::texel_t rand_texel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'hFFFFFF;
      default: return htb_pkg::texel_t'($urandom());
    endcase
  endfunction

  function automatic int rand_height();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7) return int'($urandom_range(0, 26000)) - 4000;
    if (mode < 9) return int'($urandom_range(0, 65535));
    // near a tent center or an edge where a tent just reaches zero
    case ($urandom_range(0, 4))
      0:       return int'($urandom_range(0, 8)) - 4;
      1:       return 4915 + int'($urandom_range(0, 8)) - 4;
      2:       return 9830 + int'($urandom_range(0, 8)) - 4;
      3:       return 14746 + int'($urandom_range(0, 8)) - 4;
      default: return 3277 + int'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  // Idle percentage per side for the current traffic phase
  function automatic int idle_pct(input bit sender);
    if (accepted_cnt < PHASE1_AT) return sender ? 9 : 88;
    if (accepted_cnt < PHASE2_AT) return sender ? 88 : 9;
    return 0;
  endfunction

  task automatic report_fail(input string what, input rgb_t want, input rgb_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX)
      $display("[%0t] %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $time, what,
               want.red, want.green, want.blue, got.red, got.green, got.blue);
  endtask

  // Driver: present the next pending item once the current one has transferred
  always @(negedge clk) begin
    if (rst_n && (!drv_valid || in_taken)) begin
      if (stim_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        drv_item  <= stim_items.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    logic rdy;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rdy = 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
    sink_ready <= rdy;
  end

  // Monitor: check each result transfer, then predict from each input transfer
  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    blend_item_t cur;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_chan.valid && in_chan.ready;
      if (out_chan.valid && out_chan.ready) begin
        got.red   = out_chan.red;
        got.green = out_chan.green;
        got.blue  = out_chan.blue;
        if (expect_rgb.size() == 0) begin
          report_fail("result with nothing pending", '0, got);
        end else begin
          want = expect_rgb.pop_front();
          checked_cnt++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            report_fail("blend mismatch", want, got);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        cur = mk_item(in_chan.action, int'(in_chan.height), in_chan.texel_low,
                      in_chan.texel_medium, in_chan.texel_high, in_chan.texel_very_high);
        accepted_cnt <= accepted_cnt + 1;
        if (cur.action == ACT_BLEND) begin
          expect_rgb.push_back(blend_pixel(cur));
          blend_cnt++;
        end else begin
          set_height_weights(cur.height);
          height_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
             expect_rgb.size());
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int hgt [11];
    int i;
    for (i = 0; i < 4; i++) weight_q16[i] = htb_pkg::weight_t'(Q16_QUARTER);

    // Blends on the reset weights, then each notable height followed by a blend
    stim_items.push_back(mk_item(ACT_BLEND, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF, 24'hFFFFFF));
    stim_items.push_back(mk_item(ACT_BLEND, -32768, '0, '0, '0, '0));
    stim_items.push_back(mk_item(ACT_BLEND, 0, 24'hFF0000, 24'h00FF00,
                                 24'h0000FF, 24'hFFFFFF));
    // far below, centers, far above, low tent edge, between tents, one, all ones
    hgt = '{-32768, 0, 4915, 9830, 14746, 32767, 3277, 2458, 16384, -1, 12000};
    for (i = 0; i < 11; i++) begin
      stim_items.push_back(mk_item(ACT_HEIGHT, hgt[i], rand_texel(), rand_texel(),
                                   rand_texel(), rand_texel()));
      if (i % 3 == 0)
        stim_items.push_back(mk_item(ACT_BLEND, rand_height(), 24'hFFFFFF, 24'hFFFFFF,
                                     24'hFFFFFF, 24'hFFFFFF));
      else
        stim_items.push_back(mk_item(ACT_BLEND, rand_height(), rand_texel(), rand_texel(),
                                     rand_texel(), rand_texel()));
    end

    // Random mix, about one height update per three blends
    for (i = 0; i < RANDOM_ITEMS; i++)
      stim_items.push_back(mk_item(($urandom_range(0, 99) < 25) ? ACT_HEIGHT : ACT_BLEND,
                                   rand_height(), rand_texel(), rand_texel(),
                                   rand_texel(), rand_texel()));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_items.size() != 0 || drv_valid || expect_rgb.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expect_rgb.size() != 0) begin
      fail_cnt++;
      $display("%0d expected results never arrived", expect_rgb.size());
    end
    $display("Covered %0d items: %0d height updates, %0d blends, %0d results checked",
             accepted_cnt, height_cnt, blend_cnt, checked_cnt);
    $display("Traffic: sender gaps, sink stalls, no-idle stretch and a %0d-cycle sink hold",
             HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
